[rtl/hts_pkg.sv]
// ----------------------------------------------------------------------------
// hts_pkg: shared types and constants of the Huffman tree weighted sampler
// Sizes, status codes, controller states and the command/status bundles.
// ----------------------------------------------------------------------------
package hts_pkg;

  localparam int MAX_LEAVES = 64;
  localparam int NODE_COUNT = 2 * MAX_LEAVES - 1;
  localparam int IDX_W      = $clog2(NODE_COUNT);
  localparam int CNT_W      = $clog2(MAX_LEAVES + 1);
  localparam int LEAF_W     = 6;
  localparam int IN_WGT_W   = 16;
  localparam int WGT_W      = 22;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_OVER     = 2'd1;
  localparam logic [1:0] ST_NO_TREE  = 2'd2;
  localparam logic [1:0] ST_UNSORTED = 2'd3;

  localparam logic REQ_LOAD = 1'b0;

  typedef enum logic [3:0] {
    S_IDLE, S_BTEST, S_BL0, S_BL1, S_BI0, S_BI1, S_BWR,
    S_DROOT, S_DCHK, S_DKID, S_DWALK, S_DCMP, S_DOUT
  } state_t;

  typedef enum logic [2:0] {
    RA_LQ, RA_LQ1, RA_IH, RA_IH1, RA_NODE, RA_LC
  } raddr_sel_t;

  typedef enum logic [1:0] {
    CAP_NONE, CAP_L0, CAP_L1, CAP_I0
  } cap_sel_t;

  typedef struct packed {
    logic       load;
    logic       draw;
    raddr_sel_t raddr_sel;
    cap_sel_t   cap_sel;
    logic       bld_write;
    logic       set_over;
    logic       set_leaf;
    logic       walk_step;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic start_build;
    logic no_tree;
    logic build_more;
    logic root_over;
    logic at_leaf;
    logic out_free;
  } stat_t;

endpackage

[rtl/hts_if.sv]
// ----------------------------------------------------------------------------
// hts channel interfaces
// Request and result channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface hts_req_if import hts_pkg::*;;
  logic                valid;
  logic                ready;
  logic                req_type;
  logic [IN_WGT_W-1:0] weight;
  logic                last_weight;
  logic [WGT_W-1:0]    random_value;

  modport source(output valid, req_type, weight, last_weight, random_value, input ready);
  modport sink(input valid, req_type, weight, last_weight, random_value, output ready);
endinterface

interface hts_res_if import hts_pkg::*;;
  logic              valid;
  logic              ready;
  logic [LEAF_W-1:0] leaf_index;
  logic [1:0]        status;

  modport source(output valid, leaf_index, status, input ready);
  modport sink(input valid, leaf_index, status, output ready);
endinterface

[rtl/hts_ctrl.sv]
// ----------------------------------------------------------------------------
// hts_ctrl: sequencer for table build and tree walk
// Issues one command word per cycle to the datapath.
// ----------------------------------------------------------------------------
module hts_ctrl import hts_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  input  logic  in_req_type,
  output logic  in_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    cmd           = '0;
    cmd.raddr_sel = RA_NODE;
    cmd.cap_sel   = CAP_NONE;
    in_ready      = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_req_type == REQ_LOAD) begin
            cmd.load   = 1'b1;
            state_next = stat.start_build ? S_BTEST : S_IDLE;
          end else begin
            cmd.draw   = 1'b1;
            state_next = stat.no_tree ? S_DOUT : S_DROOT;
          end
        end
      end
      S_BTEST: state_next = stat.build_more ? S_BL0 : S_IDLE;
      S_BL0: begin
        cmd.raddr_sel = RA_LQ;
        state_next    = S_BL1;
      end
      S_BL1: begin
        cmd.raddr_sel = RA_LQ1;
        cmd.cap_sel   = CAP_L0;
        state_next    = S_BI0;
      end
      S_BI0: begin
        cmd.raddr_sel = RA_IH;
        cmd.cap_sel   = CAP_L1;
        state_next    = S_BI1;
      end
      S_BI1: begin
        cmd.raddr_sel = RA_IH1;
        cmd.cap_sel   = CAP_I0;
        state_next    = S_BWR;
      end
      S_BWR: begin
        cmd.bld_write = 1'b1;
        state_next    = S_BTEST;
      end
      S_DROOT: state_next = S_DCHK;
      S_DCHK: begin
        if (stat.root_over) begin
          cmd.set_over = 1'b1;
          state_next   = S_DOUT;
        end else begin
          state_next = S_DKID;
        end
      end
      S_DKID: begin
        if (stat.at_leaf) begin
          cmd.set_leaf = 1'b1;
          state_next   = S_DOUT;
        end else begin
          state_next = S_DWALK;
        end
      end
      S_DWALK: begin
        cmd.raddr_sel = RA_LC;
        state_next    = S_DCMP;
      end
      S_DCMP: begin
        cmd.walk_step = 1'b1;
        state_next    = S_DKID;
      end
      S_DOUT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

[rtl/hts_dp.sv]
// ----------------------------------------------------------------------------
// hts_dp: node store, queue pointers, merge and walk arithmetic
// Holds the node tables, table state and the result register.
// ----------------------------------------------------------------------------
module hts_dp import hts_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  cmd_t                cmd,
  output stat_t               stat,
  input  logic [IN_WGT_W-1:0] weight,
  input  logic                last_weight,
  input  logic [WGT_W-1:0]    random_value,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [LEAF_W-1:0]   out_leaf,
  output logic [1:0]          out_status
);

  logic [WGT_W-1:0] node_weight [NODE_COUNT];
  logic [IDX_W-1:0] left_child  [NODE_COUNT];
  logic [IDX_W-1:0] right_child [NODE_COUNT];

  logic [CNT_W-1:0]    leaf_count;
  logic                tree_built;
  logic                unsorted_seen;
  logic [IN_WGT_W-1:0] previous_weight;

  logic [IDX_W-1:0]  lq, ih, it, node;
  logic [WGT_W-1:0]  wl0, wl1, wi0, r;
  logic [WGT_W-1:0]  w_rd;
  logic [IDX_W-1:0]  lc_rd, rc_rd;
  logic [LEAF_W-1:0] res_leaf;
  logic [1:0]        res_status;

  // load bookkeeping
  logic [CNT_W-1:0] eff_cnt, cnt_new;
  logic             room, uns_new;

  always_comb begin
    eff_cnt = tree_built ? '0 : leaf_count;
    room    = eff_cnt < CNT_W'(MAX_LEAVES);
    uns_new = (eff_cnt != '0) &&
              (unsorted_seen || (room && weight < previous_weight));
    cnt_new = room ? eff_cnt + CNT_W'(1) : eff_cnt;
  end

  logic [IDX_W-1:0] n_idx, root_idx;
  assign n_idx    = IDX_W'(leaf_count);
  assign root_idx = IDX_W'({leaf_count, 1'b0} - (CNT_W + 1)'(2));

  // merge selection
  logic [IDX_W-1:0] leaves, ints;
  logic             cll, cli, cii;
  logic [WGT_W-1:0] ll, li, ii;
  logic [1:0]       pick;
  localparam logic [1:0] PICK_LL = 2'd0;
  localparam logic [1:0] PICK_LI = 2'd1;
  localparam logic [1:0] PICK_II = 2'd2;

  always_comb begin
    leaves = n_idx - lq;
    ints   = it - ih;
    cll    = leaves >= IDX_W'(2);
    cli    = (leaves != '0) && (ints != '0);
    cii    = ints >= IDX_W'(2);
    ll     = wl0 + wl1;
    li     = wl0 + wi0;
    ii     = wi0 + w_rd;
    if (cll && cli && cii) begin
      if (ll > li) pick = (li > ii) ? PICK_II : PICK_LI;
      else         pick = (ll < ii) ? PICK_LL : PICK_II;
    end else if (cll && cli) begin
      pick = (li > ll) ? PICK_LL : PICK_LI;
    end else if (cli && cii) begin
      pick = (li > ii) ? PICK_II : PICK_LI;
    end else if (cll) begin
      pick = PICK_LL;
    end else if (cli) begin
      pick = PICK_LI;
    end else begin
      pick = PICK_II;
    end
  end

  // memory ports
  logic [IDX_W-1:0] raddr;
  always_comb begin
    case (cmd.raddr_sel)
      RA_LQ:   raddr = lq;
      RA_LQ1:  raddr = lq + IDX_W'(1);
      RA_IH:   raddr = ih;
      RA_IH1:  raddr = ih + IDX_W'(1);
      RA_LC:   raddr = lc_rd;
      default: raddr = node;
    endcase
  end

  always_ff @(posedge clk) begin
    w_rd  <= node_weight[raddr];
    lc_rd <= left_child[node];
    rc_rd <= right_child[node];
    if (cmd.load && room) begin
      node_weight[IDX_W'(eff_cnt)] <= WGT_W'(weight);
    end else if (cmd.bld_write) begin
      unique case (pick)
        PICK_LL: node_weight[it] <= ll;
        PICK_LI: node_weight[it] <= li;
        default: node_weight[it] <= ii;
      endcase
    end
    if (cmd.bld_write) begin
      unique case (pick)
        PICK_LL: begin
          left_child[it]  <= lq;
          right_child[it] <= lq + IDX_W'(1);
        end
        PICK_LI: begin
          left_child[it]  <= lq;
          right_child[it] <= ih;
        end
        default: begin
          left_child[it]  <= ih;
          right_child[it] <= ih + IDX_W'(1);
        end
      endcase
    end
  end

  // table state
  always_ff @(posedge clk) begin
    if (rst) begin
      leaf_count      <= '0;
      tree_built      <= 1'b0;
      unsorted_seen   <= 1'b0;
      previous_weight <= '0;
    end else if (cmd.load) begin
      if (room) previous_weight <= weight;
      unsorted_seen <= uns_new;
      tree_built    <= stat.start_build;
      leaf_count    <= (last_weight && cnt_new != '0 && uns_new) ? '0 : cnt_new;
    end
  end

  // queue pointers, captures and walk registers
  always_ff @(posedge clk) begin
    if (cmd.load && stat.start_build) begin
      lq <= '0;
      ih <= IDX_W'(cnt_new);
      it <= IDX_W'(cnt_new);
    end
    unique case (cmd.cap_sel)
      CAP_L0:  wl0 <= w_rd;
      CAP_L1:  wl1 <= w_rd;
      CAP_I0:  wi0 <= w_rd;
      default: ;
    endcase
    if (cmd.bld_write) begin
      it <= it + IDX_W'(1);
      unique case (pick)
        PICK_LL: lq <= lq + IDX_W'(2);
        PICK_LI: begin
          lq <= lq + IDX_W'(1);
          ih <= ih + IDX_W'(1);
        end
        default: ih <= ih + IDX_W'(2);
      endcase
    end
    if (cmd.draw) begin
      r          <= random_value;
      node       <= root_idx;
      res_leaf   <= '0;
      res_status <= stat.no_tree ? (unsorted_seen ? ST_UNSORTED : ST_NO_TREE) : ST_OK;
    end
    if (cmd.set_over) res_status <= ST_OVER;
    if (cmd.set_leaf) res_leaf <= node[LEAF_W-1:0];
    if (cmd.walk_step) begin
      if (r <= w_rd) begin
        node <= lc_rd;
      end else begin
        r    <= r - w_rd;
        node <= rc_rd;
      end
    end
  end

  // result register: hold until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_leaf   <= res_leaf;
      out_status <= res_status;
    end
  end

  always_comb begin
    stat.start_build = last_weight && cnt_new != '0 && !uns_new;
    stat.no_tree     = !tree_built || leaf_count == '0;
    stat.build_more  = {1'b0, it} < ({leaf_count, 1'b0} - (CNT_W + 1)'(1));
    stat.root_over   = r > w_rd;
    stat.at_leaf     = node < n_idx;
    stat.out_free    = !out_valid || out_ready;
  end

`ifndef NO_ASSERTIONS
  a_tree_has_leaves: assert property (@(posedge clk) disable iff (rst)
    tree_built |-> leaf_count != '0) else $error("built tree with no leaves");
  a_merge_has_pair: assert property (@(posedge clk) disable iff (rst)
    cmd.bld_write |-> (cll || cli || cii)) else $error("merge with no pair");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || out_ready)) else $error("result overwritten");
`endif

endmodule

[rtl/huffman_tree_weighted_sampler_core.sv]
// ----------------------------------------------------------------------------
// huffman_tree_weighted_sampler_core: Huffman tree build and weighted draw
// Loads leaf weights, builds a two-queue Huffman tree and samples leaves.
// ----------------------------------------------------------------------------
// Use:
//   req carries request beats. A load beat (req_type 0) stores one leaf
//   weight; the beat with last_weight set builds the tree if the weights are
//   non-decreasing. A draw beat (req_type 1) walks the tree with random_value
//   and returns one res beat with leaf_index and status. Loads return no beat.
// Sequence:
//   One request is in work at a time; req.ready is high while the sequencer
//   idles. The final load then runs n - 1 merges for n leaves, each stepping
//   through a test, four operand reads and one write, as the node store has
//   a single read port.
//   A draw is accepted, then reads the root weight, checks the range and
//   tests for a leaf; each tree level then reads a weight, compares and
//   tests for a leaf, and the result is posted last. A value above the total
//   posts after the range check; a draw with no tree goes straight to posting.
// Reset:
//   rst clears the table (no leaves, no tree) and empties the result
//   register; node tables are not cleared and are written before read.
// Stall:
//   A finished result holds in the res register until taken; new loads are
//   accepted meanwhile. A second draw holds in its last step until the
//   register frees.
// ----------------------------------------------------------------------------
module huffman_tree_weighted_sampler_core import hts_pkg::*; (
  input logic       clk,
  input logic       rst,
  hts_req_if.sink   req,
  hts_res_if.source res
);

  cmd_t  cmd;
  stat_t stat;

  // sequencer: accepts beats and steps the datapath
  hts_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (req.valid),
    .in_req_type (req.req_type),
    .in_ready    (req.ready),
    .stat        (stat),
    .cmd         (cmd)
  );

  // datapath: node store, merge selection, walk and result register
  hts_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .weight       (req.weight),
    .last_weight  (req.last_weight),
    .random_value (req.random_value),
    .out_valid    (res.valid),
    .out_ready    (res.ready),
    .out_leaf     (res.leaf_index),
    .out_status   (res.status)
  );

endmodule
